FILE: rtl/dbc_pkg.sv
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared widths, codes and defaults of the delimiter balance checker.
// ----------------------------------------------------------------------------
package dbc_pkg;

   localparam int STACK_DEPTH_DEFAULT   = 64;
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int DEPTH_BITS_DEFAULT    = $clog2(STACK_DEPTH_DEFAULT + 1);

   localparam int STATUS_BITS = 3;
   localparam int CLASS_BITS  = 2;
   localparam int KIND_BITS   = 2;

   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [CLASS_BITS-1:0]  class_type;
   typedef logic [KIND_BITS-1:0]   kind_type;

   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_UNEXPECTED   = 3'd1;
   localparam status_type ST_MISMATCH     = 3'd2;
   localparam status_type ST_UNTERMINATED = 3'd3;
   localparam status_type ST_OVERFLOW     = 3'd4;
   localparam status_type ST_HALTED       = 3'd5;

   localparam class_type CLASS_OPEN  = 2'd1;
   localparam class_type CLASS_CLOSE = 2'd2;

endpackage

FILE: rtl/dbc_if.sv
// ----------------------------------------------------------------------------
// dbc_if
// Token and result channels of the delimiter balance checker.
// ----------------------------------------------------------------------------
interface dbc_req_if #(
   parameter int POSITION_BITS = dbc_pkg::POSITION_BITS_DEFAULT
) ();
   logic                     valid;
   logic                     ready;
   logic                     is_end;
   dbc_pkg::class_type       token_class;
   dbc_pkg::kind_type        delim_kind;
   logic [POSITION_BITS-1:0] token_position;

   modport source (output valid, is_end, token_class, delim_kind, token_position,
                   input ready);
   modport sink   (input valid, is_end, token_class, delim_kind, token_position,
                   output ready);
endinterface

interface dbc_rsp_if #(
   parameter int POSITION_BITS = dbc_pkg::POSITION_BITS_DEFAULT,
   parameter int DEPTH_BITS    = dbc_pkg::DEPTH_BITS_DEFAULT
) ();
   logic                     valid;
   logic                     ready;
   dbc_pkg::status_type      status;
   dbc_pkg::kind_type        expected_kind;
   logic [POSITION_BITS-1:0] opener_position;
   logic [DEPTH_BITS-1:0]    nesting_depth;

   modport source (output valid, status, expected_kind, opener_position, nesting_depth,
                   input ready);
   modport sink   (input valid, status, expected_kind, opener_position, nesting_depth,
                   output ready);
endinterface

FILE: rtl/dbc_stack_mem.sv
// ----------------------------------------------------------------------------
// dbc_stack_mem
// Single-write, single-read stack store with registered read and write bypass.
// ----------------------------------------------------------------------------
module dbc_stack_mem #(
   parameter int DEPTH     = dbc_pkg::STACK_DEPTH_DEFAULT,
   parameter int ADDR_BITS = $clog2(dbc_pkg::STACK_DEPTH_DEFAULT),
   parameter int DATA_BITS = dbc_pkg::KIND_BITS + dbc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] stack_mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
   end

   // a word pushed this cycle may be the one read for the next pop
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= stack_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dbc_match.sv
// ----------------------------------------------------------------------------
// dbc_match
// Stack state and per-token decision: push, pop, compare and error status.
// ----------------------------------------------------------------------------
module dbc_match #(
   parameter int STACK_DEPTH   = dbc_pkg::STACK_DEPTH_DEFAULT,
   parameter int POSITION_BITS = dbc_pkg::POSITION_BITS_DEFAULT,
   parameter int DEPTH_BITS    = $clog2(STACK_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     is_end,
   input  dbc_pkg::class_type       token_class,
   input  dbc_pkg::kind_type        delim_kind,
   input  logic [POSITION_BITS-1:0] token_position,
   output dbc_pkg::status_type      status,
   output dbc_pkg::kind_type        expected_kind,
   output logic [POSITION_BITS-1:0] opener_position,
   output logic [DEPTH_BITS-1:0]    nesting_depth
);

   localparam int ADDR_BITS  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int ENTRY_BITS = dbc_pkg::KIND_BITS + POSITION_BITS;
   localparam logic [DEPTH_BITS-1:0] FULL = DEPTH_BITS'(STACK_DEPTH);

   // top and second entries live in registers, deeper ones in the memory
   logic [DEPTH_BITS-1:0] depth_ff, depth_in, depth_eff;
   logic                  failed_ff, failed_in;
   logic [ENTRY_BITS-1:0] top_ff, top_in;
   logic [ENTRY_BITS-1:0] second_ff, second_in;
   logic                  push, wr_en;
   logic [DEPTH_BITS-1:0] depth_m2, depth_m3;
   logic [ENTRY_BITS-1:0] rd_data;
   dbc_pkg::kind_type     top_kind;

   assign top_kind = top_ff[ENTRY_BITS-1 -: dbc_pkg::KIND_BITS];

   always_comb begin
      status          = dbc_pkg::ST_OK;
      expected_kind   = '0;
      opener_position = '0;
      depth_in        = depth_ff;
      failed_in       = failed_ff;
      top_in          = top_ff;
      second_in       = second_ff;
      push            = 1'b0;
      priority if (is_end) begin
         if (failed_ff) begin
            status = dbc_pkg::ST_HALTED;
         end else if (depth_ff != '0) begin
            status          = dbc_pkg::ST_UNTERMINATED;
            expected_kind   = top_kind;
            opener_position = top_ff[POSITION_BITS-1:0];
         end
         depth_in  = '0;
         failed_in = 1'b0;
      end else if (failed_ff) begin
         status = dbc_pkg::ST_HALTED;
      end else if (token_class == dbc_pkg::CLASS_OPEN) begin
         if (depth_ff == FULL) begin
            status    = dbc_pkg::ST_OVERFLOW;
            failed_in = 1'b1;
         end else begin
            push      = 1'b1;
            top_in    = {delim_kind, token_position};
            second_in = top_ff;
            depth_in  = depth_ff + DEPTH_BITS'(1);
         end
      end else if (token_class == dbc_pkg::CLASS_CLOSE) begin
         if (depth_ff == '0) begin
            status    = dbc_pkg::ST_UNEXPECTED;
            failed_in = 1'b1;
         end else if (top_kind != delim_kind) begin
            status          = dbc_pkg::ST_MISMATCH;
            expected_kind   = top_kind;
            opener_position = top_ff[POSITION_BITS-1:0];
            failed_in       = 1'b1;
         end else begin
            top_in    = second_ff;
            second_in = rd_data;
            depth_in  = depth_ff - DEPTH_BITS'(1);
         end
      end else begin
         // other tokens leave the stack as it is
      end
   end

   assign nesting_depth = depth_in;

   // old second entry spills to memory on a push; prefetch the entry under
   // the next second so that the next pop finds it ready, also after a stall
   assign depth_eff = step ? depth_in : depth_ff;
   assign depth_m2  = depth_ff - DEPTH_BITS'(2);
   assign depth_m3  = depth_eff - DEPTH_BITS'(3);
   assign wr_en     = step && push && (depth_ff >= DEPTH_BITS'(2));

   dbc_stack_mem #(
      .DEPTH     (STACK_DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (ENTRY_BITS)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (depth_m2[ADDR_BITS-1:0]),
      .wr_data (second_ff),
      .rd_addr (depth_m3[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         failed_ff <= 1'b0;
      end else if (step) begin
         depth_ff  <= depth_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         top_ff    <= top_in;
         second_ff <= second_in;
      end
   end

endmodule

FILE: rtl/delimiter_balance_checker.sv
// ----------------------------------------------------------------------------
// delimiter_balance_checker
// Balanced bracket matcher over a lexer token stream, one token per cycle unless the result channel stalls.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              word
//  req_chan  in   valid / ready          is_end, token_class, delim_kind,
//                                        token_position
//  rsp_chan  out  valid / ready          status, expected_kind,
//                                        opener_position, nesting_depth
//
//  one token per cycle sustained unless the result channel stalls; a token is
//  taken into the input register and its result word then into the result register
//  the top two stack entries sit in registers and the rest in a one-write,
//  one-read memory whose registered read is prefetched for the next pop
//  reset clears the depth and the error flag at once; no clearing pass
//  a stalled result holds; the input register keeps taking words until it
//  and the result register are both full
// ----------------------------------------------------------------------------
module delimiter_balance_checker #(
   parameter int STACK_DEPTH   = dbc_pkg::STACK_DEPTH_DEFAULT,
   parameter int POSITION_BITS = dbc_pkg::POSITION_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   dbc_req_if.sink     req_chan,
   dbc_rsp_if.source   rsp_chan
);

   localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);

   logic                     in_valid_ff, in_valid_in;
   logic                     in_is_end_ff;
   dbc_pkg::class_type       in_class_ff;
   dbc_pkg::kind_type        in_kind_ff;
   logic [POSITION_BITS-1:0] in_position_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   dbc_pkg::status_type      rsp_status_ff;
   dbc_pkg::kind_type        rsp_kind_ff;
   logic [POSITION_BITS-1:0] rsp_position_ff;
   logic [DEPTH_BITS-1:0]    rsp_depth_ff;

   logic                     advance, step, req_take;
   dbc_pkg::status_type      status;
   dbc_pkg::kind_type        expected_kind;
   logic [POSITION_BITS-1:0] opener_position;
   logic [DEPTH_BITS-1:0]    nesting_depth;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   dbc_match #(
      .STACK_DEPTH   (STACK_DEPTH),
      .POSITION_BITS (POSITION_BITS),
      .DEPTH_BITS    (DEPTH_BITS)
   ) u_match (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .is_end          (in_is_end_ff),
      .token_class     (in_class_ff),
      .delim_kind      (in_kind_ff),
      .token_position  (in_position_ff),
      .status          (status),
      .expected_kind   (expected_kind),
      .opener_position (opener_position),
      .nesting_depth   (nesting_depth)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_is_end_ff   <= req_chan.is_end;
         in_class_ff    <= req_chan.token_class;
         in_kind_ff     <= req_chan.delim_kind;
         in_position_ff <= req_chan.token_position;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_status_ff   <= status;
         rsp_kind_ff     <= expected_kind;
         rsp_position_ff <= opener_position;
         rsp_depth_ff    <= nesting_depth;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.expected_kind   = rsp_kind_ff;
   assign rsp_chan.opener_position = rsp_position_ff;
   assign rsp_chan.nesting_depth   = rsp_depth_ff;

endmodule

FILE: rtl/dbc_checker.sv
// ----------------------------------------------------------------------------
// dbc_checker
// Port-level checks on the result channel of the delimiter balance checker.
// ----------------------------------------------------------------------------
module dbc_checker #(
   parameter int STACK_DEPTH   = dbc_pkg::STACK_DEPTH_DEFAULT,
   parameter int POSITION_BITS = dbc_pkg::POSITION_BITS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input dbc_pkg::status_type           rsp_status,
   input dbc_pkg::kind_type             rsp_expected_kind,
   input logic [POSITION_BITS-1:0]      rsp_opener_position,
   input logic [$clog2(STACK_DEPTH+1)-1:0] rsp_nesting_depth
);

   localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_expected_kind) && $stable(rsp_opener_position)
         && $stable(rsp_nesting_depth))
      else $error("result word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nesting_depth <= DEPTH_BITS'(STACK_DEPTH))
      else $error("nesting depth beyond stack size");

   // an unterminated report clears the stack, an unexpected closer finds it empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dbc_pkg::ST_UNTERMINATED
         || rsp_status == dbc_pkg::ST_UNEXPECTED) |-> rsp_nesting_depth == '0)
      else $error("nonzero depth with empty-stack status");

   // an overflow leaves the stack full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dbc_pkg::ST_OVERFLOW
         |-> rsp_nesting_depth == DEPTH_BITS'(STACK_DEPTH))
      else $error("overflow reported on a stack that is not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dbc_pkg::ST_MISMATCH
         && rsp_status != dbc_pkg::ST_UNTERMINATED
         |-> rsp_expected_kind == '0 && rsp_opener_position == '0)
      else $error("opener fields set on a status that carries none");

endmodule

bind delimiter_balance_checker dbc_checker #(
   .STACK_DEPTH   (STACK_DEPTH),
   .POSITION_BITS (POSITION_BITS)
) u_dbc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_expected_kind   (rsp_chan.expected_kind),
   .rsp_opener_position (rsp_chan.opener_position),
   .rsp_nesting_depth   (rsp_chan.nesting_depth)
);
